@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file plsq_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ hdl/plsq_pkg.sv @@
package plsq_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;

	// log10(2) in Q0.32
	localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_INFINITE    = 3'd1;
	localparam logic [2:0] ST_NO_SOLUTION = 3'd2;
	localparam logic [2:0] ST_BAD_SAMPLE  = 3'd3;
	localparam logic [2:0] ST_TOO_MANY    = 3'd4;

	// index of the last of the products that build D, Dx and Dy
	localparam logic [2:0] LAST_PROD = 3'd5;

	typedef struct packed {
		logic       take;
		logic       log_start;
		logic       acc_mul;
		logic       acc_add;
		logic       solve_clear;
		logic       mul_load;
		logic       mul_pp;
		logic [2:0] prod_idx;
		logic [1:0] pp_idx;
		logic       div_load;
		logic       div_sel;
		logic       div_step;
		logic       div_store;
		logic       srch_init;
		logic       srch_start;
		logic       srch_update;
		logic [4:0] srch_bit;
		logic       out_write;
	} cmd_t;

	typedef struct packed {
		logic sum_en;
		logic last;
		logic flag_err;
		logic x_done;
		logic y_done;
		logic d_zero;
	} sts_t;

endpackage

@@ hdl/plsq_log10.sv @@
module plsq_log10 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        value,
	output logic               done,
	output logic signed [31:0] result
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_NORM = 3'd1;
	localparam logic [2:0] PH_SQ   = 3'd2;
	localparam logic [2:0] PH_MUL  = 3'd3;
	localparam logic [2:0] PH_RND  = 3'd4;

	logic [2:0]         phase_q;
	logic [4:0]         step_q;
	logic               done_q;
	logic [31:0]        v_q;
	logic [4:0]         sh_q;
	logic [23:0]        frac_q;
	logic [60:0]        prod_q;
	logic               neg_q;
	logic signed [31:0] result_q;

	logic [4:0]  norm_w;
	logic        norm_zero;
	logic [63:0] sq_prod;
	logic [32:0] sq_t;
	logic        sq_bit;
	logic [31:0] sq_next;
	logic [5:0]  l2_exp;
	logic [29:0] l2;
	logic [29:0] l2_mag;
	logic [60:0] rnd_sum;
	logic [28:0] rnd_mag;

	always_comb begin
		case (step_q)
			5'd0: begin
				norm_w    = 5'd16;
				norm_zero = (v_q[31:16] == 16'd0);
			end
			5'd1: begin
				norm_w    = 5'd8;
				norm_zero = (v_q[31:24] == 8'd0);
			end
			5'd2: begin
				norm_w    = 5'd4;
				norm_zero = (v_q[31:28] == 4'd0);
			end
			5'd3: begin
				norm_w    = 5'd2;
				norm_zero = (v_q[31:30] == 2'd0);
			end
			default: begin
				norm_w    = 5'd1;
				norm_zero = !v_q[31];
			end
		endcase
	end

	// square the Q1.31 mantissa, renormalize into [1, 2)
	assign sq_prod = 64'(v_q) * 64'(v_q);
	assign sq_t    = sq_prod[63:31];
	assign sq_bit  = sq_t[32];
	assign sq_next = sq_bit ? sq_t[32:1] : sq_t[31:0];

	assign l2_exp  = 6'd15 - {1'b0, sh_q};
	assign l2      = {l2_exp, frac_q};
	assign l2_mag  = l2[29] ? (30'd0 - l2) : l2;
	assign rnd_sum = prod_q + 61'h80000000;
	assign rnd_mag = rnd_sum[60:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= 5'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_NORM;
						step_q  <= 5'd0;
					end
				end
				PH_NORM: begin
					if (step_q == 5'd4) begin
						phase_q <= PH_SQ;
						step_q  <= 5'd0;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				PH_SQ: begin
					if (step_q == 5'd23) begin
						phase_q <= PH_MUL;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				PH_MUL: phase_q <= PH_RND;
				PH_RND: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					v_q  <= value;
					sh_q <= 5'd0;
				end
			end
			PH_NORM: begin
				if (norm_zero) begin
					v_q  <= v_q << norm_w;
					sh_q <= sh_q + norm_w;
				end
			end
			PH_SQ: begin
				v_q    <= sq_next;
				frac_q <= {frac_q[22:0], sq_bit};
			end
			PH_MUL: begin
				prod_q <= 61'(l2_mag) * 61'(plsq_pkg::LOG10_2_Q32);
				neg_q  <= l2[29];
			end
			PH_RND: begin
				result_q <= neg_q ? (32'sd0 - $signed(32'(rnd_mag))) : $signed(32'(rnd_mag));
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ hdl/plsq_dp.sv @@
module plsq_dp #(
	parameter int MAX_SAMPLES = plsq_pkg::MAX_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plsq_pkg::cmd_t       cmd,
	output plsq_pkg::sts_t       sts,
	input  logic [31:0]          x_in,
	input  logic [31:0]          y_in,
	input  logic                 last_in,
	output logic [31:0]          coeff_a,
	output logic signed [31:0]   exponent_b,
	output logic [2:0]           fit_status,
	output logic [10:0]          sample_total
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic [CW-1:0] count_q;
	logic          bad_q;
	logic          over_q;
	logic          last_q;
	logic          sum_en_q;
	logic [47:0]   sum_x_q;
	logic [47:0]   sum_y_q;
	logic [63:0]   sum_xx_q;
	logic [63:0]   sum_xy_q;

	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [63:0] pxx_s1;
	logic [63:0] pxy_s1;

	logic [63:0]  a_mag_q;
	logic [63:0]  b_mag_q;
	logic         mneg_q;
	logic [1:0]   dsel_q;
	logic [127:0] d_q;
	logic [127:0] dx_q;
	logic [127:0] dy_q;

	logic [127:0] num_q;
	logic [127:0] den_q;
	logic [127:0] rem_q;
	logic [127:0] quo_q;
	logic         dneg_q;
	logic signed [31:0] av_q;
	logic signed [31:0] bv_q;
	logic [31:0]  res_q;

	logic [31:0]        ux_value;
	logic               ux_start;
	logic               ux_done;
	logic               uy_done;
	logic signed [31:0] lx;
	logic signed [31:0] ly;

	logic [63:0]  s1;
	logic [63:0]  s4;
	logic [63:0]  nval;
	logic [63:0]  opa;
	logic [63:0]  opb;
	logic         opsub;
	logic [1:0]   opdst;
	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] dst_cur;
	logic [127:0] dst_new;

	logic [127:0] num_sel;
	logic [127:0] rem_sh;
	logic         rem_ge;
	logic [31:0]  q_lim;
	logic [31:0]  q_sat;
	logic [31:0]  q_val;
	logic [31:0]  cand;
	logic [2:0]   status;
	logic         d_zero;
	logic         dxdy_zero;
	logic         sample_zero;

	localparam logic [1:0] DST_D  = 2'd0;
	localparam logic [1:0] DST_DX = 2'd1;
	localparam logic [1:0] DST_DY = 2'd2;

	assign cand     = res_q | (32'd1 << cmd.srch_bit);
	assign ux_value = cmd.srch_start ? cand : x_q;
	assign ux_start = cmd.log_start | cmd.srch_start;

	plsq_log10 u_log_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ux_start),
		.value  (ux_value),
		.done   (ux_done),
		.result (lx)
	);

	plsq_log10 u_log_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.value  (y_q),
		.done   (uy_done),
		.result (ly)
	);

	assign sample_zero = (x_in == 32'd0) || (y_in == 32'd0);

	assign s1   = {{16{sum_x_q[47]}}, sum_x_q};
	assign s4   = {{16{sum_y_q[47]}}, sum_y_q};
	assign nval = 64'(count_q);

	// D = n*s2 - s1*s1, Dx = s2*s4 - s1*s3, Dy = n*s3 - s1*s4
	always_comb begin
		case (cmd.prod_idx)
			3'd0: begin opa = nval;     opb = sum_xx_q; opsub = 1'b0; opdst = DST_D;  end
			3'd1: begin opa = s1;       opb = s1;       opsub = 1'b1; opdst = DST_D;  end
			3'd2: begin opa = sum_xx_q; opb = s4;       opsub = 1'b0; opdst = DST_DX; end
			3'd3: begin opa = s1;       opb = sum_xy_q; opsub = 1'b1; opdst = DST_DX; end
			3'd4: begin opa = nval;     opb = sum_xy_q; opsub = 1'b0; opdst = DST_DY; end
			default: begin opa = s1;    opb = s4;       opsub = 1'b1; opdst = DST_DY; end
		endcase
	end

	assign a_half = cmd.pp_idx[1] ? a_mag_q[63:32] : a_mag_q[31:0];
	assign b_half = cmd.pp_idx[0] ? b_mag_q[63:32] : b_mag_q[31:0];
	assign pp     = 64'(a_half) * 64'(b_half);

	always_comb begin
		case (cmd.pp_idx)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		case (dsel_q)
			DST_D:   dst_cur = d_q;
			DST_DX:  dst_cur = dx_q;
			default: dst_cur = dy_q;
		endcase
	end

	assign dst_new = mneg_q ? (dst_cur - pp_sh) : (dst_cur + pp_sh);

	assign num_sel = cmd.div_sel ? (dy_q << 24) : dx_q;
	assign rem_sh  = {rem_q[126:0], num_q[127]};
	assign rem_ge  = (rem_sh >= den_q);
	assign q_lim   = dneg_q ? 32'h80000000 : 32'h7FFFFFFF;
	assign q_sat   = ((quo_q[127:32] != 96'd0) || (quo_q[31:0] > q_lim)) ? q_lim : quo_q[31:0];
	assign q_val   = dneg_q ? (32'd0 - q_sat) : q_sat;

	assign d_zero    = (d_q == 128'd0);
	assign dxdy_zero = (dx_q == 128'd0) && (dy_q == 128'd0);

	always_comb begin
		if (over_q) begin
			status = plsq_pkg::ST_TOO_MANY;
		end else if (bad_q) begin
			status = plsq_pkg::ST_BAD_SAMPLE;
		end else if (d_zero) begin
			status = dxdy_zero ? plsq_pkg::ST_INFINITE : plsq_pkg::ST_NO_SOLUTION;
		end else begin
			status = plsq_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			bad_q    <= 1'b0;
			over_q   <= 1'b0;
			last_q   <= 1'b0;
			sum_en_q <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_xy_q <= '0;
		end else begin
			if (cmd.take) begin
				last_q <= last_in;
				if (count_q == CW'(MAX_SAMPLES)) begin
					over_q   <= 1'b1;
					sum_en_q <= 1'b0;
				end else begin
					count_q <= count_q + CW'(1);
					if (sample_zero) begin
						bad_q    <= 1'b1;
						sum_en_q <= 1'b0;
					end else begin
						sum_en_q <= 1'b1;
					end
				end
			end
			if (cmd.acc_add) begin
				sum_x_q  <= sum_x_q + {{16{lx[31]}}, lx};
				sum_y_q  <= sum_y_q + {{16{ly[31]}}, ly};
				sum_xx_q <= sum_xx_q + pxx_s1;
				sum_xy_q <= sum_xy_q + pxy_s1;
			end
			// drop the whole set once its result is out
			if (cmd.out_write) begin
				count_q  <= '0;
				bad_q    <= 1'b0;
				over_q   <= 1'b0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_xy_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q <= x_in;
			y_q <= y_in;
		end
		if (cmd.acc_mul) begin
			pxx_s1 <= 64'(lx) * 64'(lx);
			pxy_s1 <= 64'(lx) * 64'(ly);
		end
		if (cmd.solve_clear) begin
			d_q  <= '0;
			dx_q <= '0;
			dy_q <= '0;
		end
		if (cmd.mul_load) begin
			a_mag_q <= opa[63] ? (64'd0 - opa) : opa;
			b_mag_q <= opb[63] ? (64'd0 - opb) : opb;
			mneg_q  <= opa[63] ^ opb[63] ^ opsub;
			dsel_q  <= opdst;
		end
		if (cmd.mul_pp) begin
			case (dsel_q)
				DST_D:   d_q  <= dst_new;
				DST_DX:  dx_q <= dst_new;
				default: dy_q <= dst_new;
			endcase
		end
		if (cmd.div_load) begin
			num_q  <= num_sel[127] ? (128'd0 - num_sel) : num_sel;
			den_q  <= d_q[127] ? (128'd0 - d_q) : d_q;
			dneg_q <= num_sel[127] ^ d_q[127];
			rem_q  <= '0;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_sh - den_q) : rem_sh;
			quo_q <= {quo_q[126:0], rem_ge};
			num_q <= {num_q[126:0], 1'b0};
		end
		if (cmd.div_store) begin
			if (cmd.div_sel) begin
				bv_q <= $signed(q_val);
			end else begin
				av_q <= $signed(q_val);
			end
		end
		if (cmd.srch_init) begin
			res_q <= '0;
		end
		// keep the bit when the candidate's log does not exceed A
		if (cmd.srch_update && (lx <= av_q)) begin
			res_q <= cand;
		end
		if (cmd.out_write) begin
			fit_status   <= status;
			coeff_a      <= (status == plsq_pkg::ST_OK) ? res_q : 32'd0;
			exponent_b   <= (status == plsq_pkg::ST_OK) ? bv_q : 32'sd0;
			sample_total <= 11'(count_q);
		end
	end

	assign sts.sum_en   = sum_en_q;
	assign sts.last     = last_q;
	assign sts.flag_err = over_q | bad_q;
	assign sts.x_done   = ux_done;
	assign sts.y_done   = uy_done;
	assign sts.d_zero   = d_zero;

endmodule

@@ hdl/plsq_ctrl.sv @@
module plsq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output plsq_pkg::cmd_t cmd,
	input  plsq_pkg::sts_t sts
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_TAKEN  = 5'd1;
	localparam logic [4:0] S_LOGW   = 5'd2;
	localparam logic [4:0] S_AMUL   = 5'd3;
	localparam logic [4:0] S_AADD   = 5'd4;
	localparam logic [4:0] S_CHECK  = 5'd5;
	localparam logic [4:0] S_SCLR   = 5'd6;
	localparam logic [4:0] S_PLOAD  = 5'd7;
	localparam logic [4:0] S_PPP    = 5'd8;
	localparam logic [4:0] S_DZ     = 5'd9;
	localparam logic [4:0] S_DLOAD  = 5'd10;
	localparam logic [4:0] S_DSTEP  = 5'd11;
	localparam logic [4:0] S_DSTORE = 5'd12;
	localparam logic [4:0] S_SINIT  = 5'd13;
	localparam logic [4:0] S_SSTART = 5'd14;
	localparam logic [4:0] S_SWAIT  = 5'd15;
	localparam logic [4:0] S_SUPD   = 5'd16;
	localparam logic [4:0] S_OUT    = 5'd17;

	logic [4:0] state_q;
	logic [2:0] prod_q;
	logic [1:0] pp_q;
	logic [6:0] div_cnt_q;
	logic       div_sel_q;
	logic [4:0] bit_q;
	logic       m_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.prod_idx = prod_q;
		cmd.pp_idx   = pp_q;
		cmd.div_sel  = div_sel_q;
		cmd.srch_bit = bit_q;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			S_TAKEN:  cmd.log_start   = sts.sum_en;
			S_AMUL:   cmd.acc_mul     = 1'b1;
			S_AADD:   cmd.acc_add     = 1'b1;
			S_SCLR:   cmd.solve_clear = 1'b1;
			S_PLOAD:  cmd.mul_load    = 1'b1;
			S_PPP:    cmd.mul_pp      = 1'b1;
			S_DLOAD:  cmd.div_load    = 1'b1;
			S_DSTEP:  cmd.div_step    = 1'b1;
			S_DSTORE: cmd.div_store   = 1'b1;
			S_SINIT:  cmd.srch_init   = 1'b1;
			S_SSTART: cmd.srch_start  = 1'b1;
			S_SUPD:   cmd.srch_update = 1'b1;
			S_OUT:    cmd.out_write   = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			prod_q    <= 3'd0;
			pp_q      <= 2'd0;
			div_cnt_q <= 7'd0;
			div_sel_q <= 1'b0;
			bit_q     <= 5'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.out_write) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_TAKEN;
				S_TAKEN: state_q <= sts.sum_en ? S_LOGW : S_CHECK;
				S_LOGW:  if (sts.y_done) state_q <= S_AMUL;
				S_AMUL:  state_q <= S_AADD;
				S_AADD:  state_q <= S_CHECK;
				S_CHECK: begin
					if (!sts.last) begin
						state_q <= S_IDLE;
					end else if (sts.flag_err) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCLR;
					end
				end
				S_SCLR: begin
					prod_q  <= 3'd0;
					state_q <= S_PLOAD;
				end
				S_PLOAD: begin
					pp_q    <= 2'd0;
					state_q <= S_PPP;
				end
				S_PPP: begin
					if (pp_q == 2'd3) begin
						if (prod_q == plsq_pkg::LAST_PROD) begin
							state_q <= S_DZ;
						end else begin
							prod_q  <= prod_q + 3'd1;
							state_q <= S_PLOAD;
						end
					end else begin
						pp_q <= pp_q + 2'd1;
					end
				end
				S_DZ: begin
					div_sel_q <= 1'b0;
					state_q   <= sts.d_zero ? S_OUT : S_DLOAD;
				end
				S_DLOAD: begin
					div_cnt_q <= 7'd0;
					state_q   <= S_DSTEP;
				end
				S_DSTEP: begin
					if (div_cnt_q == 7'd127) begin
						state_q <= S_DSTORE;
					end else begin
						div_cnt_q <= div_cnt_q + 7'd1;
					end
				end
				S_DSTORE: begin
					if (div_sel_q) begin
						state_q <= S_SINIT;
					end else begin
						div_sel_q <= 1'b1;
						state_q   <= S_DLOAD;
					end
				end
				S_SINIT: begin
					bit_q   <= 5'd31;
					state_q <= S_SSTART;
				end
				S_SSTART: state_q <= S_SWAIT;
				S_SWAIT:  if (sts.x_done) state_q <= S_SUPD;
				S_SUPD: begin
					if (bit_q == 5'd0) begin
						state_q <= S_OUT;
					end else begin
						bit_q   <= bit_q - 5'd1;
						state_q <= S_SSTART;
					end
				end
				S_OUT: if (cmd.out_write) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

@@ hdl/power_law_least_squares_fit.sv @@
// Power-law fit y = a * x^b over a set of unsigned Q16.16 sample pairs, by least
// squares on log10 values. One sample is taken at a time; the wait from its
// acceptance until the next one can be accepted is set by the log10 unit
// (5 normalize steps, 24 squaring steps on one 32x32 multiplier, scale and
// round), with x and y done in parallel by two such units. A zero or dropped
// sample skips the log10 units. The sample flagged with tlast then runs the
// solve, unless the set holds a zero or dropped sample: six 64x64 products
// of four 32x32 steps each, two 128-step restoring divisions (skipped when D
// is zero) and a 32-step search for a that reruns the log10 unit once a bit.
// The result waits in an output register while the next set is taken.
module power_law_least_squares_fit #(
	parameter int MAX_SAMPLES = plsq_pkg::MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // x_value[31:0], y_value[63:32]
	input  logic        s_tlast,   // last sample of the set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // coeff_a[31:0], exponent_b[63:32],
	                               // fit_status[66:64], sample_total[77:67], zero
);

	plsq_pkg::cmd_t cmd;
	plsq_pkg::sts_t sts;

	logic [31:0]        coeff_a;
	logic signed [31:0] exponent_b;
	logic [2:0]         fit_status;
	logic [10:0]        sample_total;

	plsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	plsq_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.x_in         (s_tdata[31:0]),
		.y_in         (s_tdata[63:32]),
		.last_in      (s_tlast),
		.coeff_a      (coeff_a),
		.exponent_b   (exponent_b),
		.fit_status   (fit_status),
		.sample_total (sample_total)
	);

	assign m_tdata = {2'b00, sample_total, fit_status, exponent_b, coeff_a};

endmodule

@@ hdl/plsq_checker.sv @@
`include "assert_macros.svh"

module plsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	logic s_xfer;
	logic m_stall;
	logic err_res;

	assign s_xfer  = s_tvalid && s_tready;
	assign m_stall = m_tvalid && !m_tready;
	assign err_res = m_tvalid && (m_tdata[66:64] != plsq_pkg::ST_OK);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_stall, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_stall, $stable(m_tdata))
	// a failed fit carries zero coefficients
	`ASSERT_IMPLY(a_err_zero, clk, arst_n, err_res, m_tdata[63:0] == 64'd0)
	// one sample in flight at a time
	`ASSERT_NEXT(a_one_item, clk, arst_n, s_xfer, !s_tready)

endmodule

bind power_law_least_squares_fit plsq_checker u_chk (.*);
